### design/ctp_pkg.sv
// ctp_pkg: types and constants for the cidr text parser
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package ctp_pkg;

  typedef enum logic [1:0] {
    PH_TOKEN     = 2'd0,
    PH_LEADCOLON = 2'd1,
    PH_QUAD      = 2'd2,
    PH_PREFIX    = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    FAM_NONE = 2'd0,
    FAM_V4   = 2'd1,
    FAM_V6   = 2'd2
  } family_e;

  localparam logic [4:0] GapNone = 5'd31;
  localparam logic [8:0] DecBad  = 9'h1ff;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
    logic       prefix_optional;
  } in_word_t;

  typedef struct packed {
    logic        valid_res;
    logic        is_ipv6;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [7:0]  prefix_len;
  } out_word_t;

  typedef struct packed {
    phase_e      phase;
    family_e     family;
    logic [4:0]  write_pos;
    logic [4:0]  gap_pos;
    logic [15:0] hex_group;
    logic [2:0]  hex_digits;
    logic [8:0]  dec_octet;
    logic [2:0]  octets_seen;
    logic        octet_has_digit;
    logic [7:0]  prefix_accum;
    logic        error_seen;
    logic        after_colon;
  } parse_st_t;

  function automatic parse_st_t reset_state();
    parse_st_t s;
    s.phase = PH_TOKEN;
    s.family = FAM_NONE;
    s.write_pos = '0;
    s.gap_pos = GapNone;
    s.hex_group = '0;
    s.hex_digits = '0;
    s.dec_octet = '0;
    s.octets_seen = '0;
    s.octet_has_digit = 1'b0;
    s.prefix_accum = '0;
    s.error_seen = 1'b0;
    s.after_colon = 1'b0;
    return s;
  endfunction

endpackage
`default_nettype wire

### design/ctp_finish.sv
// ctp_finish: end-of-text check, gap expansion, masking of one parsed address
// depends on ctp_pkg
`timescale 1ns / 1ps
`default_nettype none
module ctp_finish import ctp_pkg::*; (
  input  var parse_st_t  st_i,
  input  var logic [7:0] bytes_i [16],
  input  var logic       opt_i,
  output out_word_t      res_o
);

  // address completion as done on '/' or at the end
  function automatic logic fin_err(input parse_st_t s, output logic [4:0] wp_o);
    logic [4:0] wp;
    logic       err;
    wp = s.write_pos;
    err = 1'b0;
    wp_o = wp;
    if (s.phase == PH_LEADCOLON) begin
      err = 1'b1;
    end else if (s.phase == PH_TOKEN) begin
      if (s.family != FAM_V6 || s.after_colon) begin
        err = 1'b1;
      end else if (s.hex_digits != 3'd0) begin
        if (wp > 5'd14) err = 1'b1;
        else wp = wp + 5'd2;
      end
    end else begin
      if (s.octets_seen < 3'd4) err = 1'b1;
      else if (s.family == FAM_V6) wp = wp + 5'd4;
      else begin
        wp_o = 5'd16;
        return 1'b0;
      end
    end
    if (!err) begin
      if (s.gap_pos != GapNone) begin
        if (wp >= 5'd16 || s.gap_pos > wp) err = 1'b1;
        else wp = 5'd16;
      end
      if (wp != 5'd16) err = 1'b1;
    end
    wp_o = wp;
    return err;
  endfunction

  logic       ferr;
  logic [4:0] fwp;
  logic       err;
  logic [7:0] plen;
  logic       v4;
  logic [7:0] grp_b [16];
  logic [7:0] final_b [16];
  logic [4:0] raw_wp;
  logic [4:0] shift;
  logic [127:0] full;
  logic [127:0] mask;

  // the write position that the last group gives, before gap expansion
  always_comb begin
    raw_wp = st_i.write_pos;
    if (st_i.phase == PH_TOKEN && st_i.hex_digits != 3'd0) raw_wp = st_i.write_pos + 5'd2;
    if (st_i.phase == PH_QUAD) raw_wp = st_i.write_pos + 5'd4;
    shift = 5'd16 - raw_wp;
  end

  // final checks and prefix length
  always_comb begin
    ferr = fin_err(st_i, fwp);
    v4 = (st_i.family == FAM_V4);
    err = st_i.error_seen;
    plen = 8'd0;
    if (!err) begin
      if (st_i.phase != PH_PREFIX) begin
        if (!opt_i || ferr) err = 1'b1;
        else plen = v4 ? 8'd32 : 8'd128;
      end else if (!st_i.octet_has_digit || st_i.prefix_accum > (v4 ? 8'd32 : 8'd128)) begin
        err = 1'b1;
      end else begin
        plen = st_i.prefix_accum;
      end
    end
  end

  // pending hex group goes in at the write position
  always_comb begin
    grp_b = bytes_i;
    if (st_i.phase == PH_TOKEN && st_i.hex_digits != 3'd0 && st_i.write_pos <= 5'd14) begin
      grp_b[st_i.write_pos[3:0]] = st_i.hex_group[15:8];
      grp_b[st_i.write_pos[3:0] + 4'd1] = st_i.hex_group[7:0];
    end
  end

  // gap expansion: bytes past the gap move to the top end
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      final_b[i] = grp_b[i];
      if (st_i.phase != PH_PREFIX && st_i.family == FAM_V6 && st_i.gap_pos != GapNone) begin
        if (5'(i) >= st_i.gap_pos) begin
          if (5'(i) >= st_i.gap_pos + shift) final_b[i] = grp_b[4'(5'(i) - shift)];
          else final_b[i] = 8'd0;
        end
      end
    end
    for (int i = 0; i < 16; i++) full[127 - 8*i -: 8] = final_b[i];
  end

  // prefix mask and result word
  always_comb begin
    mask = (plen == 8'd0) ? '0 : ~(128'd0) << (8'd128 - plen);
    res_o = '0;
    if (!err) begin
      res_o.valid_res = 1'b1;
      res_o.prefix_len = plen;
      if (v4) begin
        res_o.addr_low = {32'd0, full[127:96] & mask[127:96]};
      end else begin
        res_o.is_ipv6 = 1'b1;
        res_o.addr_high = full[127:64] & mask[127:64];
        res_o.addr_low = full[63:0] & mask[63:0];
      end
    end
  end

endmodule
`default_nettype wire

### design/cidr_text_parser.sv
// cidr_text_parser: streaming IPv4/IPv6 CIDR text parser, one character per word
// the result word is registered and appears in the cycle after the last character is accepted
// throughput: one character per cycle while in_stall_o is low, set by the single-pass state update
// the output register is a one-word buffer; in_stall_o only rises while it is full and stalled
// reset: asynchronous, active low; clears parser state and the output valid
// depends on ctp_pkg and ctp_finish
`timescale 1ns / 1ps
`default_nettype none
module cidr_text_parser import ctp_pkg::*; (
  input  var logic      clk_i,
  input  var logic      rst_ni,
  input  var logic      in_valid_i,
  output logic          in_stall_o,
  input  var in_word_t  in_data_i,
  output logic          out_valid_o,
  input  var logic      out_stall_i,
  output out_word_t     out_data_o
);

  parse_st_t  st_q, st_d;
  logic [7:0] bytes_q [16];
  logic [7:0] bytes_d [16];
  logic       out_valid_q;
  out_word_t  out_q;
  out_word_t  fin_res;
  logic       accept;
  logic [7:0] c;
  logic       is_dec, is_hex;
  logic [3:0] hv;
  logic [8:0] dec10;
  logic [8:0] oct10;
  logic [8:0] pre10;
  parse_st_t  fin_st;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept = in_valid_i && !in_stall_o;
  assign c = in_data_i.char_code;

  // character class
  always_comb begin
    is_dec = (c >= "0" && c <= "9");
    hv = c[3:0];
    is_hex = is_dec;
    if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
      is_hex = 1'b1;
      hv = c[3:0] + 4'd9;
    end
    dec10 = 9'((st_q.dec_octet * 10) + {5'd0, hv});
    oct10 = dec10;
    pre10 = 9'(st_q.prefix_accum * 10) + {5'd0, c[3:0]};
  end

  // per-character state update
  always_comb begin
    st_d = st_q;
    bytes_d = bytes_q;
    if (!st_q.error_seen) begin
      case (st_q.phase)
        PH_TOKEN: begin
          if (is_hex) begin
            if (st_q.hex_digits >= 3'd4) st_d.error_seen = 1'b1;
            else begin
              if (st_q.dec_octet != DecBad) begin
                if (!is_dec || (st_q.hex_digits != 3'd0 && st_q.dec_octet == 9'd0)
                    || dec10 > 9'd255 || st_q.dec_octet > 9'd25)
                  st_d.dec_octet = DecBad;
                else st_d.dec_octet = dec10;
              end
              st_d.hex_group = {st_q.hex_group[11:0], hv};
              st_d.hex_digits = st_q.hex_digits + 3'd1;
              st_d.after_colon = 1'b0;
            end
          end else if (c == ":") begin
            if (st_q.family == FAM_NONE && st_q.hex_digits == 3'd0) begin
              st_d.family = FAM_V6;
              st_d.phase = PH_LEADCOLON;
            end else begin
              st_d.family = FAM_V6;
              if (st_q.hex_digits == 3'd0) begin
                if (st_q.gap_pos != GapNone) st_d.error_seen = 1'b1;
                else begin
                  st_d.gap_pos = st_q.write_pos;
                  st_d.after_colon = 1'b0;
                end
              end else begin
                if (st_q.write_pos > 5'd14) st_d.error_seen = 1'b1;
                else begin
                  bytes_d[st_q.write_pos[3:0]] = st_q.hex_group[15:8];
                  bytes_d[st_q.write_pos[3:0] + 4'd1] = st_q.hex_group[7:0];
                  st_d.write_pos = st_q.write_pos + 5'd2;
                end
                st_d.hex_group = '0;
                st_d.hex_digits = '0;
                st_d.dec_octet = '0;
                st_d.after_colon = 1'b1;
              end
            end
          end else if (c == ".") begin
            if (st_q.hex_digits == 3'd0 || st_q.dec_octet == DecBad || st_q.write_pos > 5'd12)
              st_d.error_seen = 1'b1;
            else begin
              if (st_q.family == FAM_NONE) st_d.family = FAM_V4;
              bytes_d[st_q.write_pos[3:0]] = st_q.dec_octet[7:0];
              st_d.octets_seen = 3'd1;
              st_d.octet_has_digit = 1'b0;
              st_d.dec_octet = '0;
              st_d.phase = PH_QUAD;
            end
          end else if (c == "/") begin
            st_d.phase = PH_PREFIX;
            st_d.octet_has_digit = 1'b0;
            st_d.prefix_accum = '0;
            st_d.error_seen = fin_res.valid_res ? 1'b0 : 1'b1;
          end else begin
            st_d.error_seen = 1'b1;
          end
        end
        PH_LEADCOLON: begin
          if (c == ":") begin
            st_d.gap_pos = '0;
            st_d.phase = PH_TOKEN;
          end else st_d.error_seen = 1'b1;
        end
        PH_QUAD: begin
          if (is_dec) begin
            if (st_q.octet_has_digit && st_q.dec_octet == 9'd0) st_d.error_seen = 1'b1;
            else if (oct10 > 9'd255 || st_q.dec_octet > 9'd25) st_d.error_seen = 1'b1;
            else begin
              st_d.dec_octet = oct10;
              if (!st_q.octet_has_digit) begin
                st_d.octets_seen = st_q.octets_seen + 3'd1;
                st_d.octet_has_digit = 1'b1;
              end
              if (!st_q.octet_has_digit && st_q.octets_seen >= 3'd4) st_d.error_seen = 1'b1;
              else
                bytes_d[4'(st_q.write_pos + 5'(st_d.octets_seen) - 5'd1)] = oct10[7:0];
            end
          end else if (c == ".") begin
            if (!st_q.octet_has_digit || st_q.octets_seen == 3'd4) st_d.error_seen = 1'b1;
            else begin
              st_d.dec_octet = '0;
              st_d.octet_has_digit = 1'b0;
            end
          end else if (c == "/") begin
            st_d.phase = PH_PREFIX;
            st_d.octet_has_digit = 1'b0;
            st_d.prefix_accum = '0;
            st_d.error_seen = fin_res.valid_res ? 1'b0 : 1'b1;
          end else st_d.error_seen = 1'b1;
        end
        PH_PREFIX: begin
          if (!is_dec) st_d.error_seen = 1'b1;
          else begin
            st_d.prefix_accum = (st_q.prefix_accum > 8'd25 || pre10 > 9'd255)
                                ? 8'd255 : pre10[7:0];
            st_d.octet_has_digit = 1'b1;
          end
        end
        default: st_d.error_seen = 1'b1;
      endcase
    end
  end

  // on '/', the address is completed against the current state with slash optional
  always_comb begin
    fin_st = st_q;
    fin_st.error_seen = 1'b0;
  end

  out_word_t  end_res;
  logic [7:0] exp_bytes [16];

  ctp_finish u_slash (
    .st_i   (fin_st),
    .bytes_i(bytes_q),
    .opt_i  (1'b1),
    .res_o  (fin_res)
  );

  // expand the gap into stored bytes when entering the prefix
  always_comb begin
    for (int i = 0; i < 16; i++) exp_bytes[i] = fin_res.is_ipv6
      ? (i < 8 ? fin_res.addr_high[63 - 8*i -: 8] : fin_res.addr_low[63 - 8*(i-8) -: 8])
      : (i < 4 ? fin_res.addr_low[31 - 8*i -: 8] : 8'd0);
  end

  parse_st_t end_st;
  logic [7:0] end_bytes [16];

  // next register contents; on '/' the completed address is kept
  always_comb begin
    end_st = st_d;
    end_bytes = bytes_d;
    if (c == "/" && st_q.phase != PH_PREFIX && !st_q.error_seen) begin
      end_bytes = exp_bytes;
      end_st.gap_pos = GapNone;
      end_st.write_pos = 5'd16;
    end
  end

  // end-of-text evaluation; a '/' as last character is invalid either way
  ctp_finish u_end (
    .st_i   (st_d),
    .bytes_i(bytes_d),
    .opt_i  (in_data_i.prefix_optional),
    .res_o  (end_res)
  );

  // state and byte registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= reset_state();
    end else if (accept) begin
      if (in_data_i.last_char) st_q <= reset_state();
      else st_q <= end_st;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) bytes_q[i] <= 8'd0;
    end else if (accept) begin
      if (in_data_i.last_char) begin
        for (int i = 0; i < 16; i++) bytes_q[i] <= 8'd0;
      end else begin
        bytes_q <= end_bytes;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && in_data_i.last_char) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_data_i.last_char) out_q <= end_res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

`ifndef ASSERT_OFF
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_data_i.last_char |=> st_q.phase == PH_TOKEN && !st_q.error_seen)
    else $error("state not cleared after last character");
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.valid_res |-> out_q.prefix_len == 8'd0 && !out_q.is_ipv6)
    else $error("invalid result carries fields");
  a_v4_plen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.valid_res && !out_q.is_ipv6 |-> out_q.prefix_len <= 8'd32)
    else $error("ipv4 prefix too long");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(out_q))
    else $error("stalled result lost");
`endif

endmodule
`default_nettype wire
